### rtl/core/ndvd_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// ndvd_pkg
// Shared types, codes and arithmetic helpers of the nibble DPCM voice decoder.
// ============================================================================
package ndvd_pkg;

    localparam int SampleW = 16;
    localparam int ByteW   = 8;
    localparam int NibW    = 4;

    localparam logic [NibW-1:0]  EscNibble = 4'hF;
    localparam logic [ByteW-1:0] Bias      = 8'h80;

    typedef enum logic [1:0] {
        KIND_RAW    = 2'd0,
        KIND_DIFF   = 2'd1,
        KIND_SILENT = 2'd2,
        KIND_UNUSED = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ESC_NONE = 2'd0,
        ESC_LOW  = 2'd1,
        ESC_HIGH = 2'd2
    } esc_phase_t;

    // Decoder state carried from one nibble to the next
    typedef struct packed {
        logic [ByteW-1:0] acc;
        esc_phase_t       phase;
        logic [NibW-1:0]  esc_low;
    } dec_state_t;

    typedef struct packed {
        dec_state_t st;
        logic       hit;
    } nib_step_t;

    // Result words of one item, handed to the output buffer
    typedef struct packed {
        logic [1:0]         cnt;
        logic [SampleW-1:0] samp0;
        logic [SampleW-1:0] samp1;
    } item_res_t;

    // Square-law expansion: v = b - 128, sample = 2 * v * |v|
    function automatic logic [SampleW-1:0] expand(input logic [ByteW-1:0] b);
        logic signed [ByteW:0]     v;
        logic signed [ByteW:0]     m;
        logic signed [2*ByteW+1:0] p;
        v = $signed({1'b0, b}) - $signed({1'b0, Bias});
        m = v[ByteW] ? -v : v;
        p = (2*ByteW+2)'(v) * (2*ByteW+2)'(m);
        return {p[SampleW-2:0], 1'b0};
    endfunction

    // Even code subtracts c/2, odd code adds c/2 + 1, wrapping
    function automatic logic [ByteW-1:0] apply_code(input logic [ByteW-1:0] acc,
                                                    input logic [ByteW-1:0] c);
        logic [ByteW-1:0] half;
        half = {1'b0, c[ByteW-1:1]};
        if (c[0]) begin
            return acc + half + 8'd1;
        end else begin
            return acc - half;
        end
    endfunction

    // One nibble through the escape machine
    function automatic nib_step_t take_nibble(input dec_state_t st,
                                              input logic [NibW-1:0] nib);
        nib_step_t r;
        r.st  = st;
        r.hit = 1'b0;
        case (st.phase)
            ESC_LOW: begin
                r.st.esc_low = nib;
                r.st.phase   = ESC_HIGH;
            end
            ESC_HIGH: begin
                r.st.phase = ESC_NONE;
                r.st.acc   = apply_code(st.acc, {nib, st.esc_low});
                r.hit      = 1'b1;
            end
            default: begin
                if (nib == EscNibble) begin
                    r.st.phase = ESC_LOW;
                end else begin
                    r.st.acc = apply_code(st.acc, {4'd0, nib});
                    r.hit    = 1'b1;
                end
            end
        endcase
        return r;
    endfunction

endpackage

### rtl/core/ndvd_decode.sv
`timescale 1ns / 1ps
// ============================================================================
// ndvd_decode
// Input word register, decoder state and single-pass decode of one item.
// ============================================================================
module ndvd_decode import ndvd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] src_byte
    input  logic [2:0]  s_tuser,   // [1:0] block_kind, [2] block_start
    input  logic        buf_free,
    output logic        load,
    output item_res_t   res
);

    logic             in_valid_reg;
    logic [ByteW-1:0] in_byte_reg;
    kind_t            in_kind_reg;
    logic             in_start_reg;
    dec_state_t       st_reg;
    dec_state_t       st_next;
    dec_state_t       st_base;
    nib_step_t        step_lo;
    nib_step_t        step_hi;

    assign load     = in_valid_reg && buf_free;
    assign s_tready = !in_valid_reg || buf_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_byte_reg  <= s_tdata;
            in_kind_reg  <= kind_t'(s_tuser[1:0]);
            in_start_reg <= s_tuser[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '{acc: '0, phase: ESC_NONE, esc_low: '0};
        end else if (load) begin
            st_reg <= st_next;
        end
    end

    always_comb begin
        // block start clears before the item is decoded
        if (in_start_reg) begin
            st_base = '{acc: '0, phase: ESC_NONE, esc_low: '0};
        end else begin
            st_base = st_reg;
        end
        step_lo = take_nibble(st_base, in_byte_reg[NibW-1:0]);
        step_hi = take_nibble(step_lo.st, in_byte_reg[ByteW-1:NibW]);
        st_next = st_base;
        res     = '0;
        case (in_kind_reg)
            KIND_RAW: begin
                res.cnt   = 2'd1;
                res.samp0 = expand(in_byte_reg);
            end
            KIND_SILENT: begin
                res.cnt = 2'd1;
            end
            KIND_DIFF: begin
                st_next = step_hi.st;
                res.cnt = {1'b0, step_lo.hit} + {1'b0, step_hi.hit};
                res.samp0 = step_lo.hit ? expand(step_lo.st.acc) : expand(step_hi.st.acc);
                res.samp1 = expand(step_hi.st.acc);
            end
            default: begin
                res.cnt = 2'd0;
            end
        endcase
    end

    a_two_only_diff: assert property (@(posedge aclk) disable iff (!aresetn)
        load && res.cnt == 2'd2 |-> in_kind_reg == KIND_DIFF)
        else $error("two samples from a non-difference item");

endmodule

### rtl/core/ndvd_outbuf.sv
`timescale 1ns / 1ps
// ============================================================================
// ndvd_outbuf
// Two-slot result register; shifts samples out one word per cycle while m_tready is high.
// ============================================================================
module ndvd_outbuf import ndvd_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  item_res_t           res,
    output logic                buf_free,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [SampleW-1:0]  m_tdata,   // [15:0] sample
    output logic                m_tlast    // last_of_item
);

    logic [1:0]         cnt_reg;
    logic [1:0]         cnt_next;
    logic [SampleW-1:0] slot0_reg;
    logic [SampleW-1:0] slot1_reg;
    logic               take;

    assign m_tvalid = cnt_reg != 2'd0;
    assign m_tdata  = slot0_reg;
    assign m_tlast  = cnt_reg == 2'd1;
    assign take     = m_tvalid && m_tready;
    assign buf_free = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_tready);

    always_comb begin
        cnt_next = cnt_reg;
        if (load) begin
            cnt_next = res.cnt;
        end else if (take) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
        if (load) begin
            slot0_reg <= res.samp0;
            slot1_reg <= res.samp1;
        end else if (take) begin
            slot0_reg <= slot1_reg;
        end
    end

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3)
        else $error("result count out of range");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> cnt_reg == 2'd0 || (cnt_reg == 2'd1 && m_tready))
        else $error("result buffer overwritten");

    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        take && m_tlast && !load |=> cnt_reg == 2'd0)
        else $error("buffer not empty after last word");

endmodule

### rtl/core/nibble_dpcm_voice_decoder.sv
`timescale 1ns / 1ps
// ============================================================================
// nibble_dpcm_voice_decoder
// Decodes raw, silent and nibble-DPCM voice bytes into 16-bit PCM samples.
// ============================================================================
//
//  channel | dir | word                         | handshake
//  --------+-----+------------------------------+---------------------
//  s_      | in  | tdata src_byte, tuser kind,  | s_tvalid / s_tready
//          |     |   tuser block_start          |
//  m_      | out | tdata sample, tlast last     | m_tvalid / m_tready
//
//  Path: an input word is registered, decoded in one pass and lands in a
//  two-slot result register, which drives m_tvalid. The output port moves
//  one sample per cycle while m_tready is high; raw, silent and one-sample
//  items yield one word, two-sample items two, and kind 3 or escape-only
//  items no word.
//  Reset (aresetn low, synchronous) clears the accumulator, escape state and
//  all valid flags; no clearing pass follows.
//  Stalls: while a result waits the input register takes at most one more
//  word, then s_tready drops; a low m_tready stops both stages, with nothing lost.
//
module nibble_dpcm_voice_decoder import ndvd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] src_byte
    input  logic [2:0]  s_tuser,   // [1:0] block_kind, [2] block_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] sample (signed)
    output logic        m_tlast    // last_of_item: final sample of this word
);

    logic      buf_free;
    logic      load;
    item_res_t res;

    // Input register, escape machine, accumulator and companding
    ndvd_decode u_decode (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .buf_free (buf_free),
        .load     (load),
        .res      (res)
    );

    // Hold up to two samples and shift them out in order
    ndvd_outbuf u_outbuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .res      (res),
        .buf_free (buf_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
